// File: design/keyed_histogram_accumulator_macros.svh
// Assertion macros shared by the keyed histogram accumulator RTL.
// Depends on nothing; users must have signals named clock and reset in scope.
`ifndef KEYED_HISTOGRAM_ACCUMULATOR_MACROS_SVH
`define KEYED_HISTOGRAM_ACCUMULATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KHA_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KHA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/khist_pkg.sv
// Shared constants, codes and types of the keyed histogram accumulator.
// Depends on nothing; khist_div, the top level and the testbench import it.
package khist_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int BIN_COUNT     = 10;
   localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);
   localparam int BIN_W         = 4;
   localparam int BIN_SLOTS     = TABLE_ENTRIES * BIN_COUNT;
   localparam int BIN_ADDR_W    = $clog2(BIN_SLOTS);
   localparam int KEY_W         = 32;
   localparam int VALUE_W       = 24;
   localparam int COUNT_W       = 32;
   localparam int SUM_W         = 48;
   localparam int WIDTH_W       = 16;
   localparam int QUO_W         = 16;
   localparam int DIV_CNT_W     = $clog2(QUO_W);
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd200;
   localparam logic [VALUE_W-1:0] ONE_Q8      = 24'd256;

   typedef enum logic [OP_W-1:0] {
      OP_HIST_ADD = 3'd0,
      OP_SUM_ADD  = 3'd1,
      OP_READ_BIN = 3'd2,
      OP_READ_SUM = 3'd3,
      OP_CLEAR    = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_BAD_BIN   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE,
      S_ROW_CLEAR,
      S_DIV_WAIT,
      S_BIN_READ,
      S_BIN_UPDATE,
      S_SUM_READ,
      S_SUM_UPDATE,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic               start;
      logic [QUO_W-1:0]   dividend;
      logic [WIDTH_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: design/khist_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
module khist_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/khist_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on khist_pkg for widths and the request and response structs.
module khist_div import khist_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [WIDTH_W-1:0]   divisor_ff, divisor_in;
   logic [WIDTH_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [WIDTH_W:0]     rem_shift;
   logic                 fits;

   always_comb begin
      rem_shift  = {rem_ff, quo_ff[QUO_W-1]};
      fits       = rem_shift >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = done_ff;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         done_in    = 1'b0;
         step_in    = '0;
         divisor_in = div_req.divisor;
         rem_in     = '0;
         quo_in     = div_req.dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? WIDTH_W'(rem_shift - {1'b0, divisor_ff}) : rem_shift[WIDTH_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: design/keyed_histogram_accumulator.sv
// Top level of the keyed histogram accumulator: sequencer, table state and result register.
// Depends on khist_pkg, khist_ram, khist_div and keyed_histogram_accumulator_macros.svh.
//
// Each item is handled alone. The key memory is scanned one entry per cycle until the key
// matches or the last entry has been compared. A histogram sample also needs the bin, found
// by a serial divider that runs during the scan; when the sample creates a histogram the
// entry's 10 bins are zeroed first, one per cycle. Clear, unused opcodes and a bad bin index
// go straight from idle to the response state. The result register lets the next item enter
// while a result waits; the following result then waits until the first one is taken.
`include "keyed_histogram_accumulator_macros.svh"

module keyed_histogram_accumulator import khist_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic [KEY_W-1:0]    req_counter_id,
   input  logic [VALUE_W-1:0]  req_sample_value,
   input  logic [BIN_W-1:0]    req_bin_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SUM_W-1:0]    rsp_read_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [WIDTH_W-1:0]  csr_bin_width
);

   state_type                state_ff, state_in;
   logic [WIDTH_W-1:0]       bin_width_ff, bin_width_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic [KEY_W-1:0]         key_ff, key_in;
   logic [VALUE_W-1:0]       value_ff, value_in;
   logic [BIN_W-1:0]         bin_ff, bin_in;
   logic                     small_ff, small_in;
   logic [ENTRY_W-1:0]       entry_ff, entry_in;
   logic [ENTRY_W-1:0]       scan_ff, scan_in;
   logic [ENTRY_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                     cmp_valid_ff, cmp_valid_in;
   logic                     found_ff, found_in;
   logic [BIN_W-1:0]         row_ff, row_in;
   logic [TABLE_ENTRIES-1:0] hist_present_ff, hist_present_in;
   logic [TABLE_ENTRIES-1:0] sum_present_ff, sum_present_in;
   status_type               res_status_ff, res_status_in;
   logic [SUM_W-1:0]         res_data_ff, res_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [SUM_W-1:0]         rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic [TABLE_ENTRIES-1:0] in_use;
   logic [ENTRY_W-1:0]       free_idx;
   logic                     any_free;
   logic                     key_hit;
   logic                     has_hist;
   logic                     has_sum;
   logic [ENTRY_W-1:0]       e_sel;
   logic [BIN_ADDR_W-1:0]    row_base;
   logic [BIN_ADDR_W-1:0]    bin_addr;
   logic [BIN_W-1:0]         bin_pick;
   logic [COUNT_W-1:0]       count_inc;
   logic [SUM_W:0]           sum_add;
   logic [SUM_W-1:0]         sum_sat;

   logic                     key_we;
   logic [KEY_W-1:0]         key_rdata;
   logic                     bin_we;
   logic [BIN_ADDR_W-1:0]    bin_waddr;
   logic [COUNT_W-1:0]       bin_wdata;
   logic [COUNT_W-1:0]       bin_rdata;
   logic                     sum_we;
   logic [ENTRY_W-1:0]       sum_waddr;
   logic [SUM_W-1:0]         sum_wdata;
   logic [SUM_W-1:0]         sum_rdata;
   div_req_type              div_req;
   div_rsp_type              div_rsp;

   khist_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (free_idx),
      .wr_data (key_ff),
      .rd_addr (scan_ff),
      .rd_data (key_rdata)
   );

   khist_ram #(.WIDTH(COUNT_W), .DEPTH(BIN_SLOTS)) u_bin_ram (
      .clock   (clock),
      .wr_en   (bin_we),
      .wr_addr (bin_waddr),
      .wr_data (bin_wdata),
      .rd_addr (bin_addr),
      .rd_data (bin_rdata)
   );

   khist_ram #(.WIDTH(SUM_W), .DEPTH(TABLE_ENTRIES)) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_waddr),
      .wr_data (sum_wdata),
      .rd_addr (entry_ff),
      .rd_data (sum_rdata)
   );

   khist_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign in_use    = hist_present_ff | sum_present_ff;
   assign key_hit   = in_use[cmp_idx_ff] && (key_rdata == key_ff);
   assign has_hist  = found_ff && hist_present_ff[entry_ff];
   assign has_sum   = found_ff && sum_present_ff[entry_ff];
   assign e_sel     = found_ff ? entry_ff : free_idx;
   assign row_base  = BIN_ADDR_W'(entry_ff) * BIN_ADDR_W'(BIN_COUNT);
   assign bin_addr  = row_base + BIN_ADDR_W'(bin_ff);
   assign count_inc = (bin_rdata == '1) ? bin_rdata : bin_rdata + 1'b1;
   assign sum_add   = {1'b0, sum_rdata} + (SUM_W + 1)'(value_ff);
   assign sum_sat   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!in_use[i]) begin
            free_idx = ENTRY_W'(i);
            any_free = 1'b1;
         end
      end
   end

   always_comb begin
      if (small_ff) begin
         bin_pick = '0;
      end else if (div_rsp.quotient > QUO_W'(BIN_COUNT - 1)) begin
         bin_pick = BIN_W'(BIN_COUNT - 1);
      end else begin
         bin_pick = div_rsp.quotient[BIN_W-1:0];
      end
   end

   assign bin_width_in = csr_valid ? csr_bin_width : bin_width_ff;

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      value_in        = value_ff;
      bin_in          = bin_ff;
      small_in        = small_ff;
      entry_in        = entry_ff;
      scan_in         = scan_ff;
      cmp_idx_in      = cmp_idx_ff;
      cmp_valid_in    = cmp_valid_ff;
      found_in        = found_ff;
      row_in          = row_ff;
      hist_present_in = hist_present_ff;
      sum_present_in  = sum_present_ff;
      res_status_in   = res_status_ff;
      res_data_in     = res_data_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_data_in     = rsp_data_ff;
      key_we          = 1'b0;
      bin_we          = 1'b0;
      bin_waddr       = bin_addr;
      bin_wdata       = '0;
      sum_we          = 1'b0;
      sum_waddr       = entry_ff;
      sum_wdata       = SUM_W'(value_ff);
      div_req          = '0;
      div_req.dividend = req_sample_value[VALUE_W-1:VALUE_W-QUO_W] - 1'b1;
      div_req.divisor  = bin_width_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_opcode;
               key_in        = req_counter_id;
               value_in      = req_sample_value;
               bin_in        = req_bin_index;
               small_in      = req_sample_value <= ONE_Q8;
               scan_in       = '0;
               cmp_valid_in  = 1'b0;
               res_status_in = STAT_OK;
               res_data_in   = '0;
               unique case (req_opcode)
                  OP_HIST_ADD: begin
                     div_req.start = 1'b1;
                     state_in      = S_SEARCH;
                  end
                  OP_SUM_ADD, OP_READ_SUM: begin
                     state_in = S_SEARCH;
                  end
                  OP_READ_BIN: begin
                     if ({1'b0, req_bin_index} >= (BIN_W + 1)'(BIN_COUNT)) begin
                        res_status_in = STAT_BAD_BIN;
                        state_in      = S_RESPOND;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  OP_CLEAR: begin
                     hist_present_in = '0;
                     sum_present_in  = '0;
                     state_in        = S_RESPOND;
                  end
                  default: begin
                     state_in = S_RESPOND;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            scan_in      = scan_ff + 1'b1;
            cmp_valid_in = 1'b1;
            cmp_idx_in   = scan_ff;
            if (cmp_valid_ff) begin
               if (key_hit) begin
                  found_in = 1'b1;
                  entry_in = cmp_idx_ff;
                  state_in = S_DECIDE;
               end else if (cmp_idx_ff == ENTRY_W'(TABLE_ENTRIES - 1)) begin
                  found_in = 1'b0;
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            priority if ((op_ff == OP_HIST_ADD || op_ff == OP_SUM_ADD) && !found_ff
                         && !any_free) begin
               res_status_in = STAT_FULL;
               state_in      = S_RESPOND;
            end else begin
               unique case (op_ff)
                  OP_HIST_ADD: begin
                     key_we   = !found_ff;
                     entry_in = e_sel;
                     if (!has_hist) begin
                        hist_present_in[e_sel] = 1'b1;
                        row_in                 = '0;
                        state_in               = S_ROW_CLEAR;
                     end else begin
                        state_in = S_DIV_WAIT;
                     end
                  end
                  OP_SUM_ADD: begin
                     key_we   = !found_ff;
                     entry_in = e_sel;
                     if (!has_sum) begin
                        sum_we                = 1'b1;
                        sum_waddr             = e_sel;
                        sum_present_in[e_sel] = 1'b1;
                        state_in              = S_RESPOND;
                     end else begin
                        state_in = S_SUM_READ;
                     end
                  end
                  OP_READ_BIN: begin
                     if (has_hist) begin
                        state_in = S_BIN_READ;
                     end else begin
                        res_status_in = STAT_NOT_FOUND;
                        state_in      = S_RESPOND;
                     end
                  end
                  OP_READ_SUM: begin
                     if (has_sum) begin
                        state_in = S_SUM_READ;
                     end else begin
                        res_status_in = STAT_NOT_FOUND;
                        state_in      = S_RESPOND;
                     end
                  end
                  default: begin
                     state_in = S_RESPOND;
                  end
               endcase
            end
         end
         S_ROW_CLEAR: begin
            bin_we    = 1'b1;
            bin_waddr = row_base + BIN_ADDR_W'(row_ff);
            row_in    = row_ff + 1'b1;
            if (row_ff == BIN_W'(BIN_COUNT - 1)) begin
               state_in = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               bin_in   = bin_pick;
               state_in = S_BIN_READ;
            end
         end
         S_BIN_READ: begin
            state_in = S_BIN_UPDATE;
         end
         S_BIN_UPDATE: begin
            if (op_ff == OP_HIST_ADD) begin
               bin_we    = 1'b1;
               bin_wdata = count_inc;
            end else begin
               res_data_in = SUM_W'(bin_rdata);
            end
            state_in = S_RESPOND;
         end
         S_SUM_READ: begin
            state_in = S_SUM_UPDATE;
         end
         S_SUM_UPDATE: begin
            if (op_ff == OP_SUM_ADD) begin
               sum_we    = 1'b1;
               sum_wdata = sum_sat;
            end else begin
               res_data_in = sum_rdata;
            end
            state_in = S_RESPOND;
         end
         S_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = res_data_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         bin_width_ff    <= WIDTH_RESET;
         cmp_valid_ff    <= 1'b0;
         hist_present_ff <= '0;
         sum_present_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         bin_width_ff    <= bin_width_in;
         cmp_valid_ff    <= cmp_valid_in;
         hist_present_ff <= hist_present_in;
         sum_present_ff  <= sum_present_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      bin_ff        <= bin_in;
      small_ff      <= small_in;
      entry_ff      <= entry_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_ff      <= found_in;
      row_ff        <= row_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_data_ff;

   `KHA_ASSERT_HOLDS(a_err_no_data, rsp_valid && rsp_status != STAT_OK, rsp_read_data == '0, "error item carries data")
   `KHA_ASSERT_HOLDS(a_div_done, state_ff == S_BIN_UPDATE && op_ff == OP_HIST_ADD, div_rsp.done, "bin used before divide finished")
   `KHA_ASSERT_HOLDS(a_bin_owned, state_ff == S_BIN_READ, hist_present_ff[entry_ff], "bin access without histogram")
   `KHA_ASSERT_NEXT(a_clear_all, accept && req_opcode == OP_CLEAR, hist_present_ff == '0 && sum_present_ff == '0, "clear left entries in use")

endmodule

// File: tb/tb.sv
// Self-checking testbench for keyed_histogram_accumulator: directed and random items, bin width
// changes between phases, random gaps on both channels, and a scoreboard with its own table model.
// Depends on khist_pkg and the keyed_histogram_accumulator RTL.
module tb;
   import khist_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int KEY_POOL      = 24;
   localparam int PHASES        = 7;
   localparam int PHASE_ITEMS   = 135;

   class hist_scoreboard;
      logic [WIDTH_W-1:0] bin_width;
      logic [KEY_W-1:0]   entry_key [TABLE_ENTRIES];
      bit                 has_hist [TABLE_ENTRIES];
      bit                 has_sum [TABLE_ENTRIES];
      logic [COUNT_W-1:0] counts [TABLE_ENTRIES][BIN_COUNT];
      logic [SUM_W-1:0]   sums [TABLE_ENTRIES];
      status_type         want_status [$];
      logic [SUM_W-1:0]   want_data [$];
      int                 errors;
      int                 seen [4];

      function new();
         bin_width = WIDTH_RESET;
         errors = 0;
         foreach (seen[i]) seen[i] = 0;
         wipe();
      endfunction

      function void wipe();
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            entry_key[i] = '0;
            has_hist[i] = 0;
            has_sum[i] = 0;
            sums[i] = '0;
            for (int j = 0; j < BIN_COUNT; j++) counts[i][j] = '0;
         end
      endfunction

      function int lookup(logic [KEY_W-1:0] key);
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if ((has_hist[i] || has_sum[i]) && entry_key[i] == key) return i;
         return -1;
      endfunction

      function int claim(logic [KEY_W-1:0] key);
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!has_hist[i] && !has_sum[i]) begin
               entry_key[i] = key;
               return i;
            end
         end
         return -1;
      endfunction

      function int bin_of(logic [VALUE_W-1:0] v);
         logic [31:0] span;
         logic [31:0] q;
         if (v <= ONE_Q8) return 0;
         span = {8'd0, bin_width, 8'd0};
         q = (span == 0) ? 32'hFFFF_FFFF : ({8'd0, v} - {8'd0, ONE_Q8}) / span;
         if (q > BIN_COUNT - 1) q = BIN_COUNT - 1;
         return int'(q);
      endfunction

      function void note_input(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                               logic [VALUE_W-1:0] v, logic [BIN_W-1:0] bi);
         status_type       st;
         logic [SUM_W-1:0] data;
         logic [SUM_W:0]   total;
         int               e;
         int               b;
         st = STAT_OK;
         data = '0;
         case (op)
            OP_HIST_ADD, OP_SUM_ADD: begin
               e = lookup(key);
               if (e < 0) e = claim(key);
               if (e < 0) begin
                  st = STAT_FULL;
               end else if (op == OP_HIST_ADD) begin
                  b = bin_of(v);
                  if (!has_hist[e]) begin
                     for (int j = 0; j < BIN_COUNT; j++) counts[e][j] = '0;
                     has_hist[e] = 1;
                  end
                  if (counts[e][b] != '1) counts[e][b] = counts[e][b] + 1;
               end else if (!has_sum[e]) begin
                  sums[e] = {{(SUM_W-VALUE_W){1'b0}}, v};
                  has_sum[e] = 1;
               end else begin
                  total = sums[e] + v;
                  sums[e] = total[SUM_W] ? '1 : total[SUM_W-1:0];
               end
            end
            OP_READ_BIN: begin
               if (bi >= BIN_COUNT) begin
                  st = STAT_BAD_BIN;
               end else begin
                  e = lookup(key);
                  if (e < 0 || !has_hist[e]) st = STAT_NOT_FOUND;
                  else data = {{(SUM_W-COUNT_W){1'b0}}, counts[e][bi]};
               end
            end
            OP_READ_SUM: begin
               e = lookup(key);
               if (e < 0 || !has_sum[e]) st = STAT_NOT_FOUND;
               else data = sums[e];
            end
            OP_CLEAR: wipe();
            default: ;
         endcase
         want_status.push_back(st);
         want_data.push_back(data);
      endfunction

      function void check_result(logic [STATUS_W-1:0] st, logic [SUM_W-1:0] data);
         status_type       exp_st;
         logic [SUM_W-1:0] exp_data;
         if (want_status.size() == 0) begin
            errors++;
            $display("%0t: unexpected item: status %0d read_data %0d", $time, st, data);
            return;
         end
         exp_st = want_status.pop_front();
         exp_data = want_data.pop_front();
         seen[st]++;
         if (st !== exp_st) begin
            errors++;
            $display("%0t: status mismatch: expected %0d actual %0d", $time, exp_st, st);
         end
         if (data !== exp_data) begin
            errors++;
            $display("%0t: read_data mismatch: expected %0d actual %0d", $time, exp_data, data);
         end
      endfunction

      function int pending();
         return want_status.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_opcode;
   logic [KEY_W-1:0]    req_counter_id;
   logic [VALUE_W-1:0]  req_sample_value;
   logic [BIN_W-1:0]    req_bin_index;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [SUM_W-1:0]    rsp_read_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [WIDTH_W-1:0]  csr_bin_width;

   hist_scoreboard      board = new();
   logic [KEY_W-1:0]    key_pool [KEY_POOL];
   logic [WIDTH_W-1:0]  width_plan [PHASES];
   bit                  quiet_gaps = 0;
   int                  items_sent = 0;
   int                  cycle_count = 0;

   keyed_histogram_accumulator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_counter_id   (req_counter_id),
      .req_sample_value (req_sample_value),
      .req_bin_index    (req_bin_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_read_data    (rsp_read_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bin_width    (csr_bin_width)
   );

   initial clock = 0;
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d items outstanding", cycle_count,
                  board.pending());
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_status, rsp_read_data);
   end

   function automatic int pick_gap();
      int r;
      if (quiet_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      int hold;
      wait (reset === 1'b0);
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            @(negedge clock) rsp_ready = 0;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock) rsp_ready = 1;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                            input logic [VALUE_W-1:0] v, input logic [BIN_W-1:0] bi);
      int gap;
      @(negedge clock);
      req_valid = 1;
      req_opcode = op;
      req_counter_id = key;
      req_sample_value = v;
      req_bin_index = bi;
      do @(posedge clock); while (!req_ready);
      board.note_input(op, key, v, bi);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_valid = 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic random_item();
      int                 r;
      int                 top;
      logic [OP_W-1:0]    op;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] v;
      logic [BIN_W-1:0]   bi;
      r = $urandom_range(0, 99);
      if (r < 35) op = OP_HIST_ADD;
      else if (r < 55) op = OP_SUM_ADD;
      else if (r < 77) op = OP_READ_BIN;
      else if (r < 95) op = OP_READ_SUM;
      else if (r < 98) op = OP_CLEAR;
      else op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, KEY_POOL - 1)];
      r = $urandom_range(0, 19);
      if (r < 2) begin
         case ($urandom_range(0, 3))
            0: v = '0;
            1: v = ONE_Q8;
            2: v = VALUE_W'(ONE_Q8 + 1);
            default: v = '1;
         endcase
      end else if (r < 11) begin
         v = VALUE_W'($urandom);
      end else begin
         top = int'(board.bin_width) * 256 * (BIN_COUNT + 1);
         if (top == 0 || top > 24'hFF_FFFF) top = 24'hFF_FFFF;
         v = VALUE_W'($urandom_range(0, top));
      end
      if ($urandom_range(0, 7) == 0) bi = BIN_W'($urandom_range(BIN_COUNT, (1 << BIN_W) - 1));
      else bi = BIN_W'($urandom_range(0, BIN_COUNT - 1));
      send_item(op, key, v, bi);
   endtask

   task automatic drain();
      @(negedge clock) req_valid = 0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [WIDTH_W-1:0] w);
      @(negedge clock);
      csr_valid = 1;
      csr_bin_width = w;
      do @(posedge clock); while (!csr_ready);
      board.bin_width = w;
      @(negedge clock) csr_valid = 0;
   endtask

   initial begin
      logic [KEY_W-1:0] key_a;
      logic [KEY_W-1:0] key_b;
      reset = 1;
      req_valid = 0;
      req_opcode = OP_CLEAR;
      req_counter_id = '0;
      req_sample_value = '0;
      req_bin_index = '0;
      rsp_ready = 0;
      csr_valid = 0;
      csr_bin_width = WIDTH_RESET;
      key_a = '1;
      key_b = '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
      width_plan = '{WIDTH_RESET, 16'd1, 16'hFFFF, 16'd0, 16'd37,
                     16'($urandom_range(2, 65534)), WIDTH_RESET};
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 0;

      send_item(OP_READ_SUM, key_a, '0, '0);
      send_item(OP_READ_BIN, key_a, '0, '1);
      send_item(OP_READ_BIN, key_a, '0, BIN_W'(BIN_COUNT));
      send_item(OP_HIST_ADD, key_a, '0, '0);
      send_item(OP_HIST_ADD, key_a, ONE_Q8, '0);
      send_item(OP_HIST_ADD, key_a, VALUE_W'(ONE_Q8 + 1), '0);
      send_item(OP_HIST_ADD, key_a, '1, '1);
      send_item(OP_HIST_ADD, key_a, VALUE_W'(ONE_Q8 + 200 * 256), '0);
      send_item(OP_READ_BIN, key_a, '0, '0);
      send_item(OP_READ_BIN, key_a, '0, BIN_W'(1));
      send_item(OP_READ_BIN, key_a, '0, BIN_W'(BIN_COUNT - 1));
      send_item(OP_READ_SUM, key_a, '0, '0);
      send_item(OP_SUM_ADD, key_a, '1, '0);
      send_item(OP_SUM_ADD, key_a, '1, '0);
      send_item(OP_READ_SUM, key_a, '0, '0);
      send_item(OP_SUM_ADD, key_b, 24'd5, '0);
      send_item(OP_READ_BIN, key_b, '0, '0);
      send_item(OP_HIST_ADD, key_b, 24'h12_3456, '0);
      send_item(OP_READ_BIN, key_b, '0, BIN_W'(BIN_COUNT - 1));
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
         send_item(OP_W'(op), key_b, '1, '1);
      send_item(OP_CLEAR, key_a, '0, '0);
      send_item(OP_READ_SUM, key_a, '0, '0);
      send_item(OP_READ_BIN, key_b, '0, '0);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            drain();
            write_width(width_plan[p]);
         end
         quiet_gaps = (p == 4);
         repeat (PHASE_ITEMS) random_item();
      end
      quiet_gaps = 0;
      drain();

      $display("Run covered %0d items over %0d bin width settings with gaps on both channels.",
               items_sent, PHASES);
      $display("Statuses seen: ok %0d, not found %0d, table full %0d, bad bin %0d.",
               board.seen[STAT_OK], board.seen[STAT_NOT_FOUND], board.seen[STAT_FULL],
               board.seen[STAT_BAD_BIN]);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
